/* sv/ahdsr_pkg.sv */
// Package for the AHDSR envelope generator: shared types, codes and constants.
// Used by every module of the block; depends on nothing.
package ahdsr_pkg;

  // Q1.12 full scale.
  localparam logic [12:0] FULL_LEVEL = 13'd4096;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] MODE_START   = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_TICK    = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_ATTACK  = 3'd0;
  localparam logic [2:0] REG_HOLD    = 3'd1;
  localparam logic [2:0] REG_DECAY   = 3'd2;
  localparam logic [2:0] REG_SUSTAIN = 3'd3;
  localparam logic [2:0] REG_RELEASE = 3'd4;
  localparam logic [2:0] REG_PITCH   = 3'd5;
  localparam logic [2:0] REG_VOLUME  = 3'd6;

  // Divider geometry: every quotient of this block stays below 2**16.
  localparam int QUO_W      = 16;
  localparam int DIVIDEND_W = 34;
  localparam int DIVISOR_W  = 17;

  // Shared multiplier geometry.
  localparam int MUL_A_W = 20;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic [15:0]        attack_ticks;
    logic [15:0]        hold_ticks;
    logic [15:0]        decay_ticks;
    logic [12:0]        sustain_level;
    logic [15:0]        release_ticks;
    logic signed [15:0] attack_pitch;
    logic [7:0]         channel_volume;
  } cfg_t;

  // Which product, quotient and write-back the datapath works on.
  typedef enum logic [2:0] {
    OP_PITCH,
    OP_ATTACK,
    OP_DECAY,
    OP_RELEASE,
    OP_CHIP1,
    OP_CHIP2
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_TICK,
    S_PMUL,
    S_PDIV,
    S_PWAIT,
    S_LEVEL,
    S_LMUL,
    S_LDIV,
    S_LWAIT,
    S_CHIP1,
    S_CHIP2,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load_item;
    logic do_start;
    logic mark_release;
    logic tick_begin;
    logic clear_active;
    logic set_sustain;
    logic set_full;
    logic rel_capture;
    logic mul_en;
    logic div_start;
    logic wb_en;
    op_t  op;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       active;
    logic       released;
    logic       rel_done;
    logic       sus_phase;
    logic       sustain_zero;
    logic       pitch_need;
    logic       in_attack;
    logic       in_hold;
    logic       div_busy;
  } status_t;

endpackage

/* sv/ahdsr_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on ahdsr_pkg for its widths; the quotient must fit in QUO_W bits.
module ahdsr_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [ahdsr_pkg::DIVIDEND_W-1:0]    dividend,
  input  logic [ahdsr_pkg::DIVISOR_W-1:0]     divisor,
  output logic                                busy,
  output logic [ahdsr_pkg::QUO_W-1:0]         quotient
);

  localparam int CNT_W = $clog2(ahdsr_pkg::QUO_W + 1);

  logic [ahdsr_pkg::DIVISOR_W-1:0] rem;
  logic [ahdsr_pkg::QUO_W-1:0]     quo;
  logic [CNT_W-1:0]                cnt;
  logic [ahdsr_pkg::DIVISOR_W:0]   trial;
  logic                            fits;

  // The upper dividend bits start as the partial remainder; they are below the divisor.
  assign trial = {rem, quo[ahdsr_pkg::QUO_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(ahdsr_pkg::QUO_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[ahdsr_pkg::DIVISOR_W+ahdsr_pkg::QUO_W-1:ahdsr_pkg::QUO_W];
      quo <= dividend[ahdsr_pkg::QUO_W-1:0];
    end else if (busy) begin
      rem <= fits ? ahdsr_pkg::DIVISOR_W'(trial - {1'b0, divisor})
                  : trial[ahdsr_pkg::DIVISOR_W-1:0];
      quo <= {quo[ahdsr_pkg::QUO_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

/* sv/ahdsr_regs.sv */
// Configuration register file behind an APB-style port.
// Depends on ahdsr_pkg for the register indexes and the cfg_t bundle.
module ahdsr_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output ahdsr_pkg::cfg_t     cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_ticks   <= '0;
      cfg.hold_ticks     <= '0;
      cfg.decay_ticks    <= '0;
      cfg.sustain_level  <= ahdsr_pkg::FULL_LEVEL;
      cfg.release_ticks  <= '0;
      cfg.attack_pitch   <= '0;
      cfg.channel_volume <= 8'd128;
    end else if (wr) begin
      unique case (idx)
        ahdsr_pkg::REG_ATTACK:  cfg.attack_ticks   <= pwdata[15:0];
        ahdsr_pkg::REG_HOLD:    cfg.hold_ticks     <= pwdata[15:0];
        ahdsr_pkg::REG_DECAY:   cfg.decay_ticks    <= pwdata[15:0];
        ahdsr_pkg::REG_SUSTAIN: cfg.sustain_level  <= pwdata[12:0];
        ahdsr_pkg::REG_RELEASE: cfg.release_ticks  <= pwdata[15:0];
        ahdsr_pkg::REG_PITCH:   cfg.attack_pitch   <= pwdata[15:0];
        ahdsr_pkg::REG_VOLUME:  cfg.channel_volume <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ahdsr_pkg::REG_ATTACK:  prdata = {16'd0, cfg.attack_ticks};
      ahdsr_pkg::REG_HOLD:    prdata = {16'd0, cfg.hold_ticks};
      ahdsr_pkg::REG_DECAY:   prdata = {16'd0, cfg.decay_ticks};
      ahdsr_pkg::REG_SUSTAIN: prdata = {19'd0, cfg.sustain_level};
      ahdsr_pkg::REG_RELEASE: prdata = {16'd0, cfg.release_ticks};
      ahdsr_pkg::REG_PITCH:   prdata = {16'd0, cfg.attack_pitch};
      ahdsr_pkg::REG_VOLUME:  prdata = {24'd0, cfg.channel_volume};
      default:                prdata = 32'd0;
    endcase
  end

endmodule

/* sv/ahdsr_datapath.sv */
// Envelope datapath: note state, shared multiplier, divider and output register.
// Depends on ahdsr_pkg and ahdsr_div; driven by ahdsr_ctrl through cmd_t.
module ahdsr_datapath #(
  parameter int TICK_COUNT_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ahdsr_pkg::cfg_t        cfg,
  input  ahdsr_pkg::cmd_t        cmd,
  output ahdsr_pkg::status_t     status,
  input  logic [1:0]             in_mode,
  input  logic [6:0]             in_velocity,
  output logic [3:0]             out_chip_level,
  output logic [12:0]            out_envelope_level,
  output logic signed [15:0]     out_pitch_offset,
  output logic                   out_note_active,
  output logic                   out_in_release
);

  localparam int TB = TICK_COUNT_BITS;
  localparam int CW = (TB > 18) ? TB : 18;

  // Note state.
  logic [TB-1:0]        tick_count;
  logic [TB-1:0]        e_reg;
  logic [15:0]          release_count;
  logic [12:0]          level_now;
  logic [12:0]          release_start;
  logic signed [15:0]   pitch_now;
  logic                 released_flag;
  logic                 active_flag;
  logic [6:0]           latched_velocity;
  logic [1:0]           item_mode;
  logic [6:0]           item_velocity;

  // Segment boundaries and derived operands.
  logic [16:0]          ah;
  logic [17:0]          ahd;
  logic [CW-1:0]        e_ext;
  logic [16:0]          ah_minus_e;
  logic [15:0]          e_decay;
  logic [12:0]          sus_clamped;
  logic [15:0]          rt_minus_rc;
  logic [12:0]          rs_sel;
  logic [15:0]          ap_mag;

  logic [ahdsr_pkg::MUL_A_W-1:0]    mul_a;
  logic [ahdsr_pkg::MUL_B_W-1:0]    mul_b;
  logic [ahdsr_pkg::PROD_W-1:0]     prod;
  logic [ahdsr_pkg::DIVISOR_W-1:0]  divisor;
  logic [ahdsr_pkg::QUO_W-1:0]      quotient;
  logic                             div_busy;
  logic [3:0]                       chip_sat;

  assign ah          = {1'b0, cfg.attack_ticks} + {1'b0, cfg.hold_ticks};
  assign ahd         = {1'b0, ah} + {2'b0, cfg.decay_ticks};
  assign e_ext       = CW'(e_reg);
  assign ah_minus_e  = ah - e_reg[16:0];
  assign e_decay     = e_reg[15:0] - ah[15:0];
  assign sus_clamped = (cfg.sustain_level > ahdsr_pkg::FULL_LEVEL) ? ahdsr_pkg::FULL_LEVEL
                                                                    : cfg.sustain_level;
  assign rt_minus_rc = cfg.release_ticks - release_count;
  assign rs_sel      = (release_count == 16'd0) ? level_now : release_start;
  assign ap_mag      = cfg.attack_pitch[15] ? (~cfg.attack_pitch + 16'd1) : cfg.attack_pitch;

  always_comb begin
    status.mode         = item_mode;
    status.active       = active_flag;
    status.released     = released_flag;
    status.rel_done     = release_count >= cfg.release_ticks;
    status.sus_phase    = e_ext >= CW'(ahd);
    status.sustain_zero = cfg.sustain_level == 13'd0;
    status.pitch_need   = (cfg.attack_pitch != 16'sd0) && (e_ext < CW'(ah));
    status.in_attack    = e_ext < CW'(cfg.attack_ticks);
    status.in_hold      = e_ext < CW'(ah);
    status.div_busy     = div_busy;
  end

  // One shared multiplier, registered.
  always_comb begin
    unique case (cmd.op)
      ahdsr_pkg::OP_PITCH: begin
        mul_a = ahdsr_pkg::MUL_A_W'(ap_mag);
        mul_b = ah_minus_e;
      end
      ahdsr_pkg::OP_ATTACK: begin
        mul_a = ahdsr_pkg::MUL_A_W'(e_reg[15:0]);
        mul_b = ahdsr_pkg::MUL_B_W'(ahdsr_pkg::FULL_LEVEL);
      end
      ahdsr_pkg::OP_DECAY: begin
        mul_a = ahdsr_pkg::MUL_A_W'(ahdsr_pkg::FULL_LEVEL - sus_clamped);
        mul_b = ahdsr_pkg::MUL_B_W'(e_decay);
      end
      ahdsr_pkg::OP_RELEASE: begin
        mul_a = ahdsr_pkg::MUL_A_W'(rs_sel);
        mul_b = ahdsr_pkg::MUL_B_W'(rt_minus_rc);
      end
      ahdsr_pkg::OP_CHIP1: begin
        mul_a = ahdsr_pkg::MUL_A_W'(level_now);
        mul_b = ahdsr_pkg::MUL_B_W'(latched_velocity);
      end
      ahdsr_pkg::OP_CHIP2: begin
        mul_a = prod[ahdsr_pkg::MUL_A_W-1:0];
        mul_b = ahdsr_pkg::MUL_B_W'(cfg.channel_volume);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= {{ahdsr_pkg::MUL_B_W{1'b0}}, mul_a} * {{ahdsr_pkg::MUL_A_W{1'b0}}, mul_b};
    end
  end

  always_comb begin
    unique case (cmd.op)
      ahdsr_pkg::OP_PITCH:   divisor = ah;
      ahdsr_pkg::OP_ATTACK:  divisor = {1'b0, cfg.attack_ticks};
      ahdsr_pkg::OP_DECAY:   divisor = {1'b0, cfg.decay_ticks};
      ahdsr_pkg::OP_RELEASE: divisor = {1'b0, cfg.release_ticks};
      default:               divisor = ahdsr_pkg::DIVISOR_W'(1);
    endcase
  end

  ahdsr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod[ahdsr_pkg::DIVIDEND_W-1:0]),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_mode     <= in_mode;
      item_velocity <= in_velocity;
    end
    if (cmd.tick_begin) begin
      e_reg <= tick_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count       <= '0;
      release_count    <= '0;
      level_now        <= '0;
      release_start    <= '0;
      pitch_now        <= '0;
      released_flag    <= 1'b0;
      active_flag      <= 1'b0;
      latched_velocity <= '0;
    end else begin
      if (cmd.do_start) begin
        latched_velocity <= item_velocity;
        tick_count       <= '0;
        release_count    <= '0;
        level_now        <= '0;
        release_start    <= '0;
        pitch_now        <= '0;
        released_flag    <= 1'b0;
        active_flag      <= 1'b1;
      end
      if (cmd.mark_release) begin
        released_flag <= 1'b1;
      end
      if (cmd.tick_begin) begin
        if (tick_count != {TB{1'b1}}) begin
          tick_count <= tick_count + 1'b1;
        end
        pitch_now <= '0;
      end
      if (cmd.clear_active) begin
        active_flag <= 1'b0;
      end
      if (cmd.set_sustain) begin
        level_now <= sus_clamped;
      end
      if (cmd.set_full) begin
        level_now <= ahdsr_pkg::FULL_LEVEL;
      end
      if (cmd.rel_capture) begin
        release_start <= rs_sel;
      end
      if (cmd.wb_en) begin
        unique case (cmd.op)
          ahdsr_pkg::OP_PITCH: begin
            pitch_now <= cfg.attack_pitch[15] ? -$signed(quotient) : $signed(quotient);
          end
          ahdsr_pkg::OP_ATTACK: level_now <= quotient[12:0];
          ahdsr_pkg::OP_DECAY:  level_now <= ahdsr_pkg::FULL_LEVEL - quotient[12:0];
          ahdsr_pkg::OP_RELEASE: begin
            level_now     <= quotient[12:0];
            release_count <= release_count + 16'd1;
          end
          default: ;
        endcase
      end
    end
  end

  // Chip level is the product shifted down by 15, saturated at 15.
  assign chip_sat = (prod[ahdsr_pkg::PROD_W-1:15] > (ahdsr_pkg::PROD_W - 15)'(15))
                  ? 4'd15 : prod[18:15];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_chip_level     <= chip_sat;
      out_envelope_level <= level_now;
      out_pitch_offset   <= pitch_now;
      out_note_active    <= active_flag;
      out_in_release     <= released_flag;
    end
  end

endmodule

/* sv/ahdsr_ctrl.sv */
// Sequencer for the envelope generator: steps one item through the datapath.
// Depends on ahdsr_pkg for state, command and status types.
module ahdsr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  ahdsr_pkg::status_t   status,
  output ahdsr_pkg::cmd_t      cmd
);

  ahdsr_pkg::state_t state;
  ahdsr_pkg::state_t state_next;
  ahdsr_pkg::op_t    lvl_op;
  logic              out_free;

  assign lvl_op   = status.released ? ahdsr_pkg::OP_RELEASE
                  : status.in_attack ? ahdsr_pkg::OP_ATTACK : ahdsr_pkg::OP_DECAY;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = state == ahdsr_pkg::S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ahdsr_pkg::S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ahdsr_pkg::S_IDLE:   if (s_tvalid) state_next = ahdsr_pkg::S_DECIDE;
      ahdsr_pkg::S_DECIDE: begin
        if (status.mode == ahdsr_pkg::MODE_TICK && status.active) begin
          state_next = ahdsr_pkg::S_TICK;
        end else begin
          state_next = ahdsr_pkg::S_CHIP1;
        end
      end
      ahdsr_pkg::S_TICK: begin
        if (status.released) begin
          state_next = status.rel_done ? ahdsr_pkg::S_CHIP1 : ahdsr_pkg::S_LMUL;
        end else if (status.sus_phase) begin
          state_next = ahdsr_pkg::S_CHIP1;
        end else if (status.pitch_need) begin
          state_next = ahdsr_pkg::S_PMUL;
        end else begin
          state_next = ahdsr_pkg::S_LEVEL;
        end
      end
      ahdsr_pkg::S_PMUL:   state_next = ahdsr_pkg::S_PDIV;
      ahdsr_pkg::S_PDIV:   state_next = ahdsr_pkg::S_PWAIT;
      ahdsr_pkg::S_PWAIT:  if (!status.div_busy) state_next = ahdsr_pkg::S_LEVEL;
      ahdsr_pkg::S_LEVEL: begin
        if (!status.in_attack && status.in_hold) begin
          state_next = ahdsr_pkg::S_CHIP1;
        end else begin
          state_next = ahdsr_pkg::S_LMUL;
        end
      end
      ahdsr_pkg::S_LMUL:   state_next = ahdsr_pkg::S_LDIV;
      ahdsr_pkg::S_LDIV:   state_next = ahdsr_pkg::S_LWAIT;
      ahdsr_pkg::S_LWAIT:  if (!status.div_busy) state_next = ahdsr_pkg::S_CHIP1;
      ahdsr_pkg::S_CHIP1:  state_next = ahdsr_pkg::S_CHIP2;
      ahdsr_pkg::S_CHIP2:  state_next = ahdsr_pkg::S_FINISH;
      ahdsr_pkg::S_FINISH: if (out_free) state_next = ahdsr_pkg::S_IDLE;
      default:             state_next = ahdsr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.op = lvl_op;
    unique case (state)
      ahdsr_pkg::S_IDLE:   cmd.load_item = s_tvalid;
      ahdsr_pkg::S_DECIDE: begin
        case (status.mode)
          ahdsr_pkg::MODE_START:   cmd.do_start     = 1'b1;
          ahdsr_pkg::MODE_RELEASE: cmd.mark_release = 1'b1;
          ahdsr_pkg::MODE_TICK:    cmd.tick_begin   = status.active;
          default: ;
        endcase
      end
      ahdsr_pkg::S_TICK: begin
        if (status.released) begin
          cmd.clear_active = status.rel_done;
        end else if (status.sus_phase) begin
          cmd.clear_active = status.sustain_zero;
          cmd.set_sustain  = !status.sustain_zero;
        end
      end
      ahdsr_pkg::S_PMUL: begin
        cmd.op     = ahdsr_pkg::OP_PITCH;
        cmd.mul_en = 1'b1;
      end
      ahdsr_pkg::S_PDIV: begin
        cmd.op        = ahdsr_pkg::OP_PITCH;
        cmd.div_start = 1'b1;
      end
      ahdsr_pkg::S_PWAIT: begin
        cmd.op    = ahdsr_pkg::OP_PITCH;
        cmd.wb_en = !status.div_busy;
      end
      ahdsr_pkg::S_LEVEL:  cmd.set_full = !status.in_attack && status.in_hold;
      ahdsr_pkg::S_LMUL: begin
        cmd.mul_en      = 1'b1;
        cmd.rel_capture = status.released;
      end
      ahdsr_pkg::S_LDIV:   cmd.div_start = 1'b1;
      ahdsr_pkg::S_LWAIT:  cmd.wb_en = !status.div_busy;
      ahdsr_pkg::S_CHIP1: begin
        cmd.op     = ahdsr_pkg::OP_CHIP1;
        cmd.mul_en = 1'b1;
      end
      ahdsr_pkg::S_CHIP2: begin
        cmd.op     = ahdsr_pkg::OP_CHIP2;
        cmd.mul_en = 1'b1;
      end
      ahdsr_pkg::S_FINISH: cmd.out_load = out_free;
      default: ;
    endcase
  end

endmodule

/* sv/ahdsr_envelope_generator_top.sv */
// AHDSR envelope generator, one note. Start, release and idle items take the short path to
// the result beat, while a tick inside a ramp takes the longest; one item is in flight at a
// time. The two divisions of a ramp tick (pitch offset, then level) on the shared radix-2
// divider make its path the long one.
// Reset (rst, synchronous, active high) clears the note state and the handshakes and loads
// the register defaults; no clearing pass is needed.
//
// Each input beat is one item: start a note, release it, or advance one envelope tick.
// Every item returns exactly one result beat showing the note state after the item.
// The result sits in an output register, so the next input beat is taken while the
// previous result still waits for m_tready.
module ahdsr_envelope_generator_top #(
  parameter int TICK_COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port, one register every 4 bytes.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [6:0] note_velocity, [7] zero
  input  logic [1:0]  s_tuser,   // [1:0] mode
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [3:0] chip_level, [16:4] envelope_level,
                                 // [32:17] pitch_offset, [33] note_active,
                                 // [34] in_release, [39:35] zero
);

  ahdsr_pkg::cfg_t    cfg;
  ahdsr_pkg::cmd_t    cmd;
  ahdsr_pkg::status_t status;

  logic [3:0]         chip_level;
  logic [12:0]        envelope_level;
  logic signed [15:0] pitch_offset;
  logic               note_active;
  logic               in_release;

  // Register file; writes should only happen while the block is idle, which the block itself does not enforce.
  ahdsr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The controller walks each item through decode, the tick branch, the optional pitch
  // and level divisions, the two-step chip level product and the output load.
  ahdsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the note state, one shared multiplier, the divider and the
  // result register.
  ahdsr_datapath #(
    .TICK_COUNT_BITS (TICK_COUNT_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .cmd                (cmd),
    .status             (status),
    .in_mode            (s_tuser),
    .in_velocity        (s_tdata[6:0]),
    .out_chip_level     (chip_level),
    .out_envelope_level (envelope_level),
    .out_pitch_offset   (pitch_offset),
    .out_note_active    (note_active),
    .out_in_release     (in_release)
  );

  assign m_tdata = {5'd0, in_release, note_active, pitch_offset, envelope_level, chip_level};

endmodule
